// ===== sv/lkr_pkg.sv =====
// ----------------------------------------------------------------------------
// lkr_pkg
// Shared types and codes for the LRU-K frame replacer.
// ----------------------------------------------------------------------------
package lkr_pkg;

  // command codes
  localparam logic [1:0] CMD_ACCESS = 2'd0;
  localparam logic [1:0] CMD_SET_EV = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_EVICT  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK            = 2'd0;
  localparam logic [1:0] ST_BAD_FRAME     = 2'd1;
  localparam logic [1:0] ST_NOT_EVICTABLE = 2'd2;

  // access count saturation and k after reset
  localparam logic [3:0] COUNT_MAX = 4'd15;
  localparam logic [3:0] K_RESET   = 4'd2;

  // per-frame bookkeeping held in a cell
  typedef struct packed {
    logic       tracked;
    logic       mark;
    logic       in_cache;
    logic [3:0] count;
  } entry_t;

  // update broadcast from the sequencer to every cell
  typedef struct packed {
    logic       apply;
    logic       unlink;
    logic       old_cache;
    logic       push;
    logic       new_cache;
    logic       write_entry;
    logic [3:0] new_count;
    logic       clear;
    logic       mark_we;
    logic       new_mark;
  } cell_cmd_t;

endpackage

// ===== sv/lru_k_frame_replacer.sv =====
// ----------------------------------------------------------------------------
// lru_k_frame_replacer
// LRU-K replacer over FRAMES frames built as a chain of frame cells with a
// small sequencer that reads the addressed cell and broadcasts updates.
// ----------------------------------------------------------------------------
//  channel  signals                                     direction
//  input    in_valid, in_stall, command, frame,         in (stall out)
//           evictable_flag
//  output   out_valid, out_stall, status, victim_found, out (stall in)
//           victim_frame, evictable_count
//  config   cfg_valid, cfg_ready, cfg_data (k_accesses) in (ready out)
//
//  access, set-evictable and remove read the target cell, then apply.
//  evict scans instead of reading: the candidate walks the cell chain one
//  cell per cycle.
//  reset clears every cell at once; no clearing pass is needed.
//  one transaction is in flight at a time; a stalled result holds the
//  sequencer before it commits the update.
// ----------------------------------------------------------------------------
module lru_k_frame_replacer #(
  parameter int FRAMES = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] command,
  input  logic [7:0] frame,
  input  logic       evictable_flag,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status,
  output logic       victim_found,
  output logic [7:0] victim_frame,
  output logic [4:0] evictable_count,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_data
);
  import lkr_pkg::*;

  localparam int IW = $clog2(FRAMES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_APPLY = 3'd3;

  logic [2:0]    state;
  logic [3:0]    k_accesses;
  logic [4:0]    ev_total;
  logic [4:0]    ev_total_next;
  logic [1:0]    cmd_q;
  logic [7:0]    frame_q;
  logic          flag_q;
  logic          range_ok;
  logic [IW-1:0] scan_cnt;
  entry_t        t_ent;
  logic [IW-1:0] t_rank;
  logic [IW-1:0] t_idx;
  cell_cmd_t     ccmd;
  logic          in_fire;
  logic          apply_fire;
  logic [1:0]    res_status;
  logic          res_found;
  logic [7:0]    res_victim;
  logic [3:0]    cnt_inc;

  entry_t        views   [FRAMES];
  logic [IW-1:0] ranks   [FRAMES];
  logic          ch_found[FRAMES+1];
  logic          ch_cache[FRAMES+1];
  logic [IW-1:0] ch_rank [FRAMES+1];
  logic [IW-1:0] ch_idx  [FRAMES+1];

  assign in_stall   = (state != S_IDLE);
  assign in_fire    = in_valid && !in_stall;
  assign apply_fire = (state == S_APPLY) && (!out_valid || !out_stall);
  assign cfg_ready  = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      k_accesses <= K_RESET;
    end else if (cfg_valid && cfg_ready) begin
      k_accesses <= cfg_data;
    end
  end

  // cell chain
  assign ch_found[0] = 1'b0;
  assign ch_cache[0] = 1'b0;
  assign ch_rank[0]  = '0;
  assign ch_idx[0]   = '0;

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    lkr_cell #(
      .FRAMES(FRAMES),
      .INDEX (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (ccmd),
      .cmd_idx (t_idx),
      .cmd_rank(t_rank),
      .ent     (views[i]),
      .rank    (ranks[i]),
      .bi_found(ch_found[i]),
      .bi_cache(ch_cache[i]),
      .bi_rank (ch_rank[i]),
      .bi_idx  (ch_idx[i]),
      .bo_found(ch_found[i+1]),
      .bo_cache(ch_cache[i+1]),
      .bo_rank (ch_rank[i+1]),
      .bo_idx  (ch_idx[i+1])
    );
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            state <= (command == CMD_EVICT) ? S_SCAN : S_READ;
          end
        end
        S_READ: begin
          state <= S_APPLY;
        end
        S_SCAN: begin
          if (scan_cnt == IW'(FRAMES - 1)) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (apply_fire) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // transaction capture, target read and scan count
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_q    <= command;
      frame_q  <= frame;
      flag_q   <= evictable_flag;
      range_ok <= ({1'b0, frame} < 9'(FRAMES));
      scan_cnt <= '0;
    end
    if (state == S_READ) begin
      t_idx  <= frame_q[IW-1:0];
      t_rank <= ranks[frame_q[IW-1:0]];
      t_ent  <= range_ok ? views[frame_q[IW-1:0]] : '0;
    end
    if (state == S_SCAN) begin
      scan_cnt       <= scan_cnt + 1'b1;
      t_idx          <= ch_idx[FRAMES];
      t_rank         <= ch_rank[FRAMES];
      t_ent.tracked  <= ch_found[FRAMES];
      t_ent.mark     <= 1'b1;
      t_ent.in_cache <= ch_cache[FRAMES];
      t_ent.count    <= '0;
    end
  end

  // result and cell update for the captured command
  assign cnt_inc = (t_ent.count < COUNT_MAX) ? t_ent.count + 1'b1 : t_ent.count;

  always_comb begin
    ccmd          = '0;
    ccmd.apply    = apply_fire;
    res_status    = ST_OK;
    res_found     = 1'b0;
    res_victim    = '0;
    ev_total_next = ev_total;
    if (cmd_q == CMD_EVICT) begin
      if (t_ent.tracked) begin
        res_found      = 1'b1;
        res_victim     = 8'(t_idx);
        ccmd.unlink    = 1'b1;
        ccmd.old_cache = t_ent.in_cache;
        ccmd.clear     = 1'b1;
        ev_total_next  = ev_total - 1'b1;
      end
    end else if (!range_ok) begin
      res_status = ST_BAD_FRAME;
    end else begin
      case (cmd_q)
        CMD_ACCESS: begin
          ccmd.write_entry = 1'b1;
          if (!t_ent.tracked) begin
            ccmd.new_count = 4'd1;
            ccmd.mark_we   = 1'b1;
            ccmd.new_mark  = 1'b0;
            ccmd.push      = 1'b1;
            ccmd.new_cache = (k_accesses <= 4'd1);
          end else begin
            ccmd.new_count = cnt_inc;
            if (t_ent.in_cache || (cnt_inc >= k_accesses)) begin
              ccmd.unlink    = 1'b1;
              ccmd.old_cache = t_ent.in_cache;
              ccmd.push      = 1'b1;
              ccmd.new_cache = 1'b1;
            end
          end
        end
        CMD_SET_EV: begin
          if (t_ent.tracked) begin
            ccmd.mark_we  = 1'b1;
            ccmd.new_mark = flag_q;
            if (!t_ent.mark && flag_q) begin
              ev_total_next = ev_total + 1'b1;
            end else if (t_ent.mark && !flag_q) begin
              ev_total_next = ev_total - 1'b1;
            end
          end
        end
        CMD_REMOVE: begin
          if (t_ent.tracked) begin
            if (!t_ent.mark) begin
              res_status = ST_NOT_EVICTABLE;
            end else begin
              ccmd.unlink    = 1'b1;
              ccmd.old_cache = t_ent.in_cache;
              ccmd.clear     = 1'b1;
              ev_total_next  = ev_total - 1'b1;
            end
          end
        end
        default: begin
          res_status = ST_OK;
        end
      endcase
    end
  end

  // evictable count
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_total <= '0;
    end else if (apply_fire) begin
      ev_total <= ev_total_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (apply_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_fire) begin
      status          <= res_status;
      victim_found    <= res_found;
      victim_frame    <= res_victim;
      evictable_count <= ev_total_next;
    end
  end

endmodule

// ===== sv/lkr_cell.sv =====
// ----------------------------------------------------------------------------
// lkr_cell
// One frame slot: holds the frame's entry and list rank, applies broadcast
// list updates, and passes the best eviction candidate on to its neighbor.
// ----------------------------------------------------------------------------
module lkr_cell #(
  parameter int FRAMES = 16,
  parameter int INDEX  = 0,
  localparam int IW    = $clog2(FRAMES)
) (
  input  logic               clk,
  input  logic               rst,
  input  lkr_pkg::cell_cmd_t cmd,
  input  logic [IW-1:0]      cmd_idx,
  input  logic [IW-1:0]      cmd_rank,
  output lkr_pkg::entry_t    ent,
  output logic [IW-1:0]      rank,
  input  logic               bi_found,
  input  logic               bi_cache,
  input  logic [IW-1:0]      bi_rank,
  input  logic [IW-1:0]      bi_idx,
  output logic               bo_found,
  output logic               bo_cache,
  output logic [IW-1:0]      bo_rank,
  output logic [IW-1:0]      bo_idx
);
  import lkr_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

  logic sel;
  logic inc;
  logic dec;
  logic own_ok;
  logic take_own;

  // neighbor rank shifts caused by unlink and push at the front
  assign sel = cmd.apply && (cmd_idx == MY_IDX);
  assign dec = cmd.unlink && ent.tracked && (ent.in_cache == cmd.old_cache) &&
               (rank > cmd_rank);
  assign inc = cmd.push && ent.tracked && (ent.in_cache == cmd.new_cache);

  // entry state
  always_ff @(posedge clk) begin
    if (rst) begin
      ent <= '0;
    end else if (sel) begin
      if (cmd.clear) begin
        ent <= '0;
      end else begin
        if (cmd.write_entry) begin
          ent.tracked <= 1'b1;
          ent.count   <= cmd.new_count;
        end
        if (cmd.mark_we) begin
          ent.mark <= cmd.new_mark;
        end
        if (cmd.push) begin
          ent.in_cache <= cmd.new_cache;
        end
      end
    end
  end

  // list rank, meaningful only while tracked
  always_ff @(posedge clk) begin
    if (sel) begin
      if (cmd.push) begin
        rank <= '0;
      end
    end else if (cmd.apply) begin
      case ({inc, dec})
        2'b10:   rank <= rank + 1'b1;
        2'b01:   rank <= rank - 1'b1;
        default: rank <= rank;
      endcase
    end
  end

  // candidate compare: history beats cache, then larger rank wins
  assign own_ok   = ent.tracked && ent.mark;
  assign take_own = own_ok && (!bi_found || (bi_cache && !ent.in_cache) ||
                    ((bi_cache == ent.in_cache) && (rank > bi_rank)));

  // candidate register toward the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      bo_found <= 1'b0;
    end else begin
      bo_found <= bi_found || own_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (take_own) begin
      bo_cache <= ent.in_cache;
      bo_rank  <= rank;
      bo_idx   <= MY_IDX;
    end else begin
      bo_cache <= bi_cache;
      bo_rank  <= bi_rank;
      bo_idx   <= bi_idx;
    end
  end

endmodule

// ===== sv/lkr_checker.sv =====
// ----------------------------------------------------------------------------
// lkr_checker
// Port-level checks on the replacer's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module lkr_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] status,
  input logic       victim_found,
  input logic [7:0] victim_frame,
  input logic [4:0] evictable_count
);
  import lkr_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) &&
    $stable(victim_found) && $stable(victim_frame) && $stable(evictable_count))
    else $error("stalled result changed");

  // no victim means a zero frame number
  a_victim_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !victim_found |-> victim_frame == 8'd0)
    else $error("victim_frame set without a victim");

  // a victim only comes with ok status
  a_victim_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && victim_found |-> status == ST_OK)
    else $error("victim reported with fault status");

  // reset empties the result channel
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind lru_k_frame_replacer lkr_checker u_lkr_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .status         (status),
  .victim_found   (victim_found),
  .victim_frame   (victim_frame),
  .evictable_count(evictable_count)
);

// ===== dv/lru_k_frame_replacer_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_k_frame_replacer_test
// Self-checking bench for the LRU-K frame replacer. A scoreboard keeps its
// own frame table and recency lists, predicts the result of every accepted
// command and checks each result in order. Traffic runs through several k
// settings and idling mixes, with directed corner cases and random sequences.
// ----------------------------------------------------------------------------
module lru_k_frame_replacer_test;
  import lkr_pkg::*;

  localparam int SLOT_COUNT = 16;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [1:0] status;
    logic       victim_found;
    logic [7:0] victim_frame;
    logic [4:0] evictable_count;
  } outcome_t;

  // predicts the replacer and checks its results in order
  class lru_k_scoreboard;
    logic       tracked [SLOT_COUNT];
    logic       mark [SLOT_COUNT];
    logic       in_cache [SLOT_COUNT];
    logic [3:0] hits [SLOT_COUNT];
    logic [3:0] rank [SLOT_COUNT];
    logic [4:0] ev_total;
    logic [3:0] k_accesses;
    outcome_t   predicted_outcomes [$];
    int         errors;

    function new();
      for (int i = 0; i < SLOT_COUNT; i++) begin
        tracked[i] = 1'b0;
        mark[i] = 1'b0;
        in_cache[i] = 1'b0;
        hits[i] = '0;
        rank[i] = '0;
      end
      ev_total = '0;
      k_accesses = K_RESET;
      errors = 0;
    endfunction

    function void set_k(logic [3:0] k);
      k_accesses = k;
    endfunction

    function int pending();
      return predicted_outcomes.size();
    endfunction

    // frames behind f in its list move up one place
    function void unlink(int f);
      for (int i = 0; i < SLOT_COUNT; i++)
        if (i != f && tracked[i] && in_cache[i] == in_cache[f] && rank[i] > rank[f])
          rank[i]--;
    endfunction

    function void to_list_head(int f, logic to_cache);
      for (int i = 0; i < SLOT_COUNT; i++)
        if (i != f && tracked[i] && in_cache[i] == to_cache)
          rank[i]++;
      in_cache[f] = to_cache;
      rank[f] = '0;
    endfunction

    // evictable frame deepest in the given list, -1 if none
    function int oldest_evictable(logic from_cache);
      int best;
      best = -1;
      for (int i = 0; i < SLOT_COUNT; i++)
        if (tracked[i] && mark[i] && in_cache[i] == from_cache &&
            (best < 0 || rank[i] > rank[best]))
          best = i;
      return best;
    endfunction

    function void forget(int f);
      unlink(f);
      tracked[f] = 1'b0;
      mark[f] = 1'b0;
      hits[f] = '0;
      in_cache[f] = 1'b0;
      ev_total--;
    endfunction

    // apply an accepted command and queue its predicted result
    function void note_command(logic [1:0] cmd, logic [7:0] f, logic flag);
      outcome_t o;
      int v;
      int idx;
      o = '0;
      idx = int'(f);
      if (cmd == CMD_EVICT) begin
        v = oldest_evictable(1'b0);
        if (v < 0) v = oldest_evictable(1'b1);
        if (v >= 0) begin
          forget(v);
          o.victim_found = 1'b1;
          o.victim_frame = v[7:0];
        end
      end else if (idx >= SLOT_COUNT) begin
        o.status = ST_BAD_FRAME;
      end else if (cmd == CMD_ACCESS) begin
        if (!tracked[idx]) begin
          tracked[idx] = 1'b1;
          mark[idx] = 1'b0;
          hits[idx] = 4'd1;
          to_list_head(idx, k_accesses <= 4'd1);
        end else begin
          if (hits[idx] < COUNT_MAX) hits[idx]++;
          if (in_cache[idx] || hits[idx] >= k_accesses) begin
            unlink(idx);
            to_list_head(idx, 1'b1);
          end
        end
      end else if (cmd == CMD_SET_EV) begin
        if (tracked[idx]) begin
          if (!mark[idx] && flag) ev_total++;
          else if (mark[idx] && !flag) ev_total--;
          mark[idx] = flag;
        end
      end else begin
        if (tracked[idx]) begin
          if (!mark[idx]) o.status = ST_NOT_EVICTABLE;
          else forget(idx);
        end
      end
      o.evictable_count = ev_total;
      predicted_outcomes.push_back(o);
    endfunction

    function void check_outcome(logic [1:0] st, logic found, logic [7:0] victim,
                                logic [4:0] count);
      outcome_t e;
      if (predicted_outcomes.size() == 0) begin
        $error("unexpected result with no command outstanding");
        errors++;
        return;
      end
      e = predicted_outcomes.pop_front();
      if (st !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, st);
        errors++;
      end
      if (found !== e.victim_found) begin
        $error("victim_found: expected %0d, actual %0d", e.victim_found, found);
        errors++;
      end
      if (victim !== e.victim_frame) begin
        $error("victim_frame: expected %0d, actual %0d", e.victim_frame, victim);
        errors++;
      end
      if (count !== e.evictable_count) begin
        $error("evictable_count: expected %0d, actual %0d", e.evictable_count, count);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] command = CMD_ACCESS;
  logic [7:0] frame = '0;
  logic       evictable_flag = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] status;
  logic       victim_found;
  logic [7:0] victim_frame;
  logic [4:0] evictable_count;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [3:0] cfg_data = K_RESET;

  lru_k_scoreboard sb;
  logic [3:0] cur_k = K_RESET;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  lru_k_frame_replacer #(
    .FRAMES(SLOT_COUNT)
  ) i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .frame          (frame),
    .evictable_flag (evictable_flag),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .victim_found   (victim_found),
    .victim_frame   (victim_frame),
    .evictable_count(evictable_count),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // accepted commands feed the predictor
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      sb.note_command(command, frame, evictable_flag);
  end

  // accepted results are checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_outcome(status, victim_found, victim_frame, evictable_count);
  end

  // receiver stall: random, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // one command transaction, with optional idle cycles before it
  task automatic send_command(logic [1:0] cmd, logic [7:0] f, logic flag);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    command <= cmd;
    frame <= f;
    evictable_flag <= flag;
    do @(posedge clk); while (in_stall);
  endtask

  // stop offering and wait for every predicted result
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_k(logic [3:0] k);
    cfg_valid <= 1'b1;
    cfg_data <= k;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_k = k;
    sb.set_k(k);
  endtask

  // corner cases at k = 2
  task automatic directed_commands();
    send_command(CMD_EVICT, 8'd0, 1'b0);
    send_command(CMD_ACCESS, 8'd255, 1'b1);
    send_command(CMD_SET_EV, 8'd16, 1'b1);
    send_command(CMD_REMOVE, 8'd200, 1'b0);
    send_command(CMD_SET_EV, 8'd5, 1'b1);
    send_command(CMD_REMOVE, 8'd5, 1'b0);
    send_command(CMD_ACCESS, 8'd0, 1'b0);
    send_command(CMD_ACCESS, 8'd15, 1'b1);
    send_command(CMD_ACCESS, 8'd0, 1'b0);
    send_command(CMD_SET_EV, 8'd0, 1'b0);
    send_command(CMD_REMOVE, 8'd0, 1'b0);
    send_command(CMD_SET_EV, 8'd0, 1'b1);
    send_command(CMD_SET_EV, 8'd15, 1'b1);
    send_command(CMD_SET_EV, 8'd15, 1'b1);
    send_command(CMD_EVICT, 8'd255, 1'b1);
    send_command(CMD_EVICT, 8'd0, 1'b0);
    send_command(CMD_EVICT, 8'd0, 1'b0);
    send_command(CMD_ACCESS, 8'd3, 1'b0);
    send_command(CMD_ACCESS, 8'd4, 1'b0);
    send_command(CMD_SET_EV, 8'd3, 1'b1);
    send_command(CMD_SET_EV, 8'd4, 1'b1);
    send_command(CMD_SET_EV, 8'd4, 1'b0);
    send_command(CMD_REMOVE, 8'd3, 1'b1);
    send_command(CMD_REMOVE, 8'd4, 1'b0);
    send_command(CMD_SET_EV, 8'd4, 1'b1);
    send_command(CMD_EVICT, 8'd0, 1'b0);
  endtask

  // mostly access runs that promote a frame and then mark it, plus noise
  task automatic random_commands(int budget);
    int sent;
    int runs;
    logic [7:0] f;
    int pick;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(9) < 7) begin
        f = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom_range(SLOT_COUNT - 1));
        runs = $urandom_range(int'(cur_k) + 2, 1);
        repeat (runs) begin
          send_command(CMD_ACCESS, f, 1'($urandom_range(1)));
          sent++;
        end
        send_command(CMD_SET_EV, f, $urandom_range(3) != 0);
        sent++;
        pick = $urandom_range(3);
        if (pick == 0) begin
          send_command(CMD_EVICT, 8'($urandom_range(255)), 1'($urandom_range(1)));
          sent++;
        end else if (pick == 1) begin
          send_command(CMD_REMOVE, f, 1'($urandom_range(1)));
          sent++;
        end
      end else begin
        f = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) :
                                       8'($urandom_range(SLOT_COUNT - 1));
        send_command(2'($urandom_range(3)), f, 1'($urandom_range(1)));
        sent++;
      end
    end
  endtask

  // main sequence: reset, phases over k settings and idling mixes
  initial begin
    logic [3:0] k_plan [6];
    sb = new();
    k_plan = '{K_RESET, 4'd15, 4'd0, 4'd1, 4'd0, K_RESET};
    k_plan[4] = 4'($urandom_range(14, 3));
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < 6; p++) begin
      if (p < 2) begin
        tx_idle_pct = 10;
        rx_idle_pct = 77;
      end else if (p < 4) begin
        tx_idle_pct = 77;
        rx_idle_pct = 10;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (p == 0) begin
        directed_commands();
      end else begin
        drain();
        write_k(k_plan[p]);
      end
      // long receiver hold-off while commands keep coming
      if (p == 5) hold_requests++;
      random_commands(p == 0 ? 150 : 170);
    end
    drain();
    repeat (SLOT_COUNT + 4) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // run limit
  initial begin
    #20000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/lkr_pkg.sv
sv/lkr_cell.sv
sv/lru_k_frame_replacer.sv
sv/lkr_checker.sv
dv/lru_k_frame_replacer_test.sv
